// ===== sv/glyph_line_wrap_layout_core_macros.svh =====
// Assertion macros used by the checker of the glyph layout core.
`ifndef GLYPH_LINE_WRAP_LAYOUT_CORE_MACROS_SVH
`define GLYPH_LINE_WRAP_LAYOUT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GLWL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("glwl: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GLWL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("glwl: next-cycle check failed");

`endif

// ===== sv/glwl_pkg.sv =====
package glwl_pkg;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [15:0]        width_scale;
        logic [15:0]        height_scale;
        logic [14:0]        char_gap;
        logic [14:0]        row_step;
        logic [14:0]        line_height;
    } glwl_cfg_t;

    // One placed glyph, handed from the front end to the vertex emitter.
    typedef struct packed {
        logic               first;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [15:0]        tl;
        logic [15:0]        tt;
        logic [15:0]        u1;
        logic [15:0]        v1;
    } glwl_desc_t;

    typedef enum logic [2:0] {
        CFG_START_X      = 3'd0,
        CFG_START_Y      = 3'd1,
        CFG_WIDTH_SCALE  = 3'd2,
        CFG_HEIGHT_SCALE = 3'd3,
        CFG_CHAR_GAP     = 3'd4,
        CFG_ROW_STEP     = 3'd5,
        CFG_LINE_HEIGHT  = 3'd6
    } glwl_cfg_idx_t;

    typedef enum logic [2:0] {
        VTX_PREV  = 3'd0,
        VTX_DEGEN = 3'd1,
        VTX_TL    = 3'd2,
        VTX_TR    = 3'd3,
        VTX_BL    = 3'd4,
        VTX_BR    = 3'd5
    } glwl_vtx_t;

    localparam logic signed [15:0] START_X_RST      = -16'sd16384;
    localparam logic signed [15:0] START_Y_RST      = 16'sd16384;
    localparam logic [15:0]        WIDTH_SCALE_RST  = 16'd16384;
    localparam logic [15:0]        HEIGHT_SCALE_RST = 16'd16384;
    localparam logic [14:0]        CHAR_GAP_RST     = 15'd0;
    localparam logic [14:0]        ROW_STEP_RST     = 15'd1638;
    localparam logic [14:0]        LINE_HEIGHT_RST  = 15'd1638;

    function automatic logic signed [15:0] sat_s16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_u16(input logic [16:0] v);
        return v[16] ? 16'hffff : v[15:0];
    endfunction

endpackage

// ===== sv/glwl_queue.sv =====
module glwl_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  glwl_pkg::glwl_desc_t push_desc,
    output logic                 head_valid,
    output glwl_pkg::glwl_desc_t head_desc,
    input  logic                 pop
);
    import glwl_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    glwl_desc_t      entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg < (PW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== sv/glwl_front.sv =====
module glwl_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  glwl_pkg::glwl_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          glyph_width,
    input  logic [15:0]          glyph_height,
    input  logic [15:0]          tex_left,
    input  logic [15:0]          tex_top,
    input  logic signed [15:0]   glyph_baseline,
    input  logic                 first_glyph,
    output logic                 push_valid,
    input  logic                 push_ready,
    output glwl_pkg::glwl_desc_t push_desc
);
    import glwl_pkg::*;

    // Stage A: scaling products, baseline shift and texture sums.
    logic [31:0]        w_prod;
    logic [31:0]        h_prod;
    logic [32:0]        w_rnd;
    logic [32:0]        h_rnd;
    logic [14:0]        w_sat;
    logic [14:0]        h_sat;
    logic signed [31:0] b_prod;
    logic signed [31:0] b_rnd;

    logic               a_valid_reg;
    logic [14:0]        a_w_reg;
    logic [14:0]        a_h_reg;
    logic signed [18:0] a_shift_reg;
    logic [15:0]        a_tl_reg;
    logic [15:0]        a_tt_reg;
    logic [15:0]        a_u1_reg;
    logic [15:0]        a_v1_reg;
    logic               a_first_reg;

    // Stage B: pen update and wrap.
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] adv0;
    logic signed [15:0] adv1;
    logic signed [15:0] ystep;
    logic               wrap;
    logic signed [15:0] gx_b;
    logic signed [15:0] gy_b;
    logic signed [15:0] pen_x_reg;
    logic signed [15:0] pen_y_reg;

    logic               b_valid_reg;
    logic signed [15:0] b_gx_reg;
    logic signed [15:0] b_gy_reg;
    logic [14:0]        b_w_reg;
    logic [14:0]        b_h_reg;
    logic signed [18:0] b_shift_reg;
    logic [15:0]        b_tl_reg;
    logic [15:0]        b_tt_reg;
    logic [15:0]        b_u1_reg;
    logic [15:0]        b_v1_reg;
    logic               b_first_reg;

    logic               rdy_a;
    logic               rdy_b;
    logic signed [15:0] gy_c;

    assign rdy_b    = !b_valid_reg || push_ready;
    assign rdy_a    = !a_valid_reg || rdy_b;
    assign in_ready = rdy_a;

    assign w_prod = {16'b0, glyph_width} * {16'b0, cfg.width_scale};
    assign h_prod = {16'b0, glyph_height} * {16'b0, cfg.height_scale};
    assign w_rnd  = {1'b0, w_prod} + 33'h8000;
    assign h_rnd  = {1'b0, h_prod} + 33'h8000;
    assign w_sat  = (w_rnd[32:31] != 2'b00) ? 15'h7fff : w_rnd[30:16];
    assign h_sat  = (h_rnd[32:31] != 2'b00) ? 15'h7fff : h_rnd[30:16];
    assign b_prod = 32'($signed({1'b0, cfg.line_height})) * 32'(glyph_baseline);
    assign b_rnd  = b_prod + 32'sd4096;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (rdy_a) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            a_w_reg     <= w_sat;
            a_h_reg     <= h_sat;
            // Arithmetic shift floors, which rounds the +4096 bias half up.
            a_shift_reg <= b_rnd[31:13];
            a_tl_reg    <= tex_left;
            a_tt_reg    <= tex_top;
            a_u1_reg    <= sat_u16({1'b0, tex_left} + {1'b0, glyph_width});
            a_v1_reg    <= sat_u16({1'b0, tex_top} + {1'b0, glyph_height});
            a_first_reg <= first_glyph;
        end
    end

    assign px    = a_first_reg ? cfg.start_x : pen_x_reg;
    assign py    = a_first_reg ? cfg.start_y : pen_y_reg;
    assign adv0  = sat_s16({{4{px[15]}}, px} + {5'b0, cfg.char_gap} + {5'b0, a_w_reg});
    assign adv1  = sat_s16({{4{cfg.start_x[15]}}, cfg.start_x} + {5'b0, cfg.char_gap}
                           + {5'b0, a_w_reg});
    assign ystep = sat_s16({{4{py[15]}}, py} - {5'b0, cfg.row_step});
    assign wrap  = (adv0 > 16'sd0);
    assign gx_b  = wrap ? cfg.start_x : px;
    assign gy_b  = wrap ? ystep : py;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            pen_x_reg   <= START_X_RST;
            pen_y_reg   <= START_Y_RST;
        end else if (rdy_b) begin
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg) begin
                pen_x_reg <= wrap ? adv1 : adv0;
                pen_y_reg <= gy_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_b && a_valid_reg) begin
            b_gx_reg    <= gx_b;
            b_gy_reg    <= gy_b;
            b_w_reg     <= a_w_reg;
            b_h_reg     <= a_h_reg;
            b_shift_reg <= a_shift_reg;
            b_tl_reg    <= a_tl_reg;
            b_tt_reg    <= a_tt_reg;
            b_u1_reg    <= a_u1_reg;
            b_v1_reg    <= a_v1_reg;
            b_first_reg <= a_first_reg;
        end
    end

    assign gy_c = sat_s16({{4{b_gy_reg[15]}}, b_gy_reg} + {b_shift_reg[18], b_shift_reg});

    always_comb begin
        push_desc.first = b_first_reg;
        push_desc.gx    = b_gx_reg;
        push_desc.gy    = gy_c;
        push_desc.dx    = sat_s16({{4{b_gx_reg[15]}}, b_gx_reg} + {5'b0, b_w_reg});
        push_desc.dy    = sat_s16({{4{gy_c[15]}}, gy_c} - {5'b0, b_h_reg});
        push_desc.tl    = b_tl_reg;
        push_desc.tt    = b_tt_reg;
        push_desc.u1    = b_u1_reg;
        push_desc.v1    = b_v1_reg;
    end

    assign push_valid = b_valid_reg;

endmodule

// ===== sv/glwl_back.sv =====
module glwl_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  glwl_pkg::glwl_desc_t head_desc,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic                 m_tlast
);
    import glwl_pkg::*;

    glwl_vtx_t          state_reg;
    glwl_vtx_t          state_next;
    glwl_vtx_t          cur_vtx;
    glwl_vtx_t          after_vtx;
    logic               load;
    logic signed [15:0] sel_x;
    logic signed [15:0] sel_y;
    logic [15:0]        sel_u;
    logic [15:0]        sel_v;
    logic               sel_last;

    logic               m_valid_reg;
    logic [63:0]        m_data_reg;
    logic               m_last_reg;
    logic signed [15:0] prev_x_reg;
    logic signed [15:0] prev_y_reg;
    logic [15:0]        prev_u_reg;
    logic [15:0]        prev_v_reg;

    // A first glyph skips the two degenerate vertices.
    assign cur_vtx = (state_reg == VTX_PREV && head_desc.first) ? VTX_TL : state_reg;
    assign load    = head_valid && (!m_valid_reg || m_tready);

    always_comb begin
        sel_x     = head_desc.gx;
        sel_y     = head_desc.gy;
        sel_u     = head_desc.tl;
        sel_v     = head_desc.tt;
        sel_last  = 1'b0;
        after_vtx = VTX_PREV;
        unique case (cur_vtx)
            VTX_PREV: begin
                sel_x     = prev_x_reg;
                sel_y     = prev_y_reg;
                sel_u     = prev_u_reg;
                sel_v     = prev_v_reg;
                after_vtx = VTX_DEGEN;
            end
            VTX_DEGEN: begin
                after_vtx = VTX_TL;
            end
            VTX_TL: begin
                after_vtx = VTX_TR;
            end
            VTX_TR: begin
                sel_x     = head_desc.dx;
                sel_u     = head_desc.u1;
                after_vtx = VTX_BL;
            end
            VTX_BL: begin
                sel_y     = head_desc.dy;
                sel_v     = head_desc.v1;
                after_vtx = VTX_BR;
            end
            VTX_BR: begin
                sel_x     = head_desc.dx;
                sel_y     = head_desc.dy;
                sel_u     = head_desc.u1;
                sel_v     = head_desc.v1;
                sel_last  = 1'b1;
                after_vtx = VTX_PREV;
            end
            default: begin
                after_vtx = VTX_PREV;
            end
        endcase

        state_next = state_reg;
        pop        = 1'b0;
        if (load) begin
            state_next = after_vtx;
            pop        = sel_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= VTX_PREV;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            prev_u_reg  <= '0;
            prev_v_reg  <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (load && sel_last) begin
                prev_x_reg <= head_desc.dx;
                prev_y_reg <= head_desc.dy;
                prev_u_reg <= head_desc.u1;
                prev_v_reg <= head_desc.v1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= {sel_v, sel_u, sel_y, sel_x};
            m_last_reg <= sel_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== sv/glyph_line_wrap_layout_core.sv =====
// Glyph line-wrap layout core.
// Input stream (s_*): one glyph per word. tdata carries the glyph size,
// texture origin and baseline offset; tuser is set on the first glyph of a
// string, which reloads the pen from start_x/start_y.
// Output stream (m_*): one vertex per word, a triangle-strip run per glyph.
// A first glyph yields four corner vertices; any other glyph yields six: the
// previous bottom-right and this top-left as degenerate vertices, then the
// four corners. tlast marks the last vertex of each glyph.
// After a glyph is accepted, it passes through the two front-end stages, the
// glyph queue and the output register before its first vertex appears.
// Throughput: while the receiver is ready, the vertex emitter sends one vertex
// per cycle, six per glyph (four for a first glyph); that port sets the rate.
// The front end keeps accepting glyphs while the queue has room, so a stalled
// receiver backs up into the queue and then into s_tready; no word is lost.
// The APB port writes the layout registers and may be used only while idle.
// Reset is synchronous and active low: registers return to their defaults,
// the pen goes to the default start position and all stages empty.
module glyph_line_wrap_layout_core (
    input  logic        aclk,
    input  logic        aresetn,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Glyph input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // glyph_width[15:0], glyph_height[31:16], tex_left[47:32], tex_top[63:48],
    // glyph_baseline[79:64]
    input  logic [79:0] s_tdata,
    // first_glyph[0]
    input  logic        s_tuser,
    // Vertex output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // vertex_x[15:0], vertex_y[31:16], vertex_u[47:32], vertex_v[63:48]
    output logic [63:0] m_tdata,
    // run_end
    output logic        m_tlast
);
    import glwl_pkg::*;

    glwl_cfg_t     cfg_reg;
    glwl_cfg_idx_t reg_idx;
    glwl_desc_t    push_desc;
    glwl_desc_t    head_desc;
    logic          push_valid;
    logic          push_ready;
    logic          head_valid;
    logic          pop;

    assign pready  = 1'b1;
    assign reg_idx = glwl_cfg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x      <= START_X_RST;
            cfg_reg.start_y      <= START_Y_RST;
            cfg_reg.width_scale  <= WIDTH_SCALE_RST;
            cfg_reg.height_scale <= HEIGHT_SCALE_RST;
            cfg_reg.char_gap     <= CHAR_GAP_RST;
            cfg_reg.row_step     <= ROW_STEP_RST;
            cfg_reg.line_height  <= LINE_HEIGHT_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                CFG_START_X:      cfg_reg.start_x      <= pwdata[15:0];
                CFG_START_Y:      cfg_reg.start_y      <= pwdata[15:0];
                CFG_WIDTH_SCALE:  cfg_reg.width_scale  <= pwdata[15:0];
                CFG_HEIGHT_SCALE: cfg_reg.height_scale <= pwdata[15:0];
                CFG_CHAR_GAP:     cfg_reg.char_gap     <= pwdata[14:0];
                CFG_ROW_STEP:     cfg_reg.row_step     <= pwdata[14:0];
                CFG_LINE_HEIGHT:  cfg_reg.line_height  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            CFG_START_X:      prdata = {16'b0, cfg_reg.start_x};
            CFG_START_Y:      prdata = {16'b0, cfg_reg.start_y};
            CFG_WIDTH_SCALE:  prdata = {16'b0, cfg_reg.width_scale};
            CFG_HEIGHT_SCALE: prdata = {16'b0, cfg_reg.height_scale};
            CFG_CHAR_GAP:     prdata = {17'b0, cfg_reg.char_gap};
            CFG_ROW_STEP:     prdata = {17'b0, cfg_reg.row_step};
            CFG_LINE_HEIGHT:  prdata = {17'b0, cfg_reg.line_height};
            default:          prdata = '0;
        endcase
    end

    glwl_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .glyph_width    (s_tdata[15:0]),
        .glyph_height   (s_tdata[31:16]),
        .tex_left       (s_tdata[47:32]),
        .tex_top        (s_tdata[63:48]),
        .glyph_baseline (s_tdata[79:64]),
        .first_glyph    (s_tuser),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_desc      (push_desc)
    );

    glwl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop)
    );

    glwl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== sv/glwl_checker.sv =====
`include "glyph_line_wrap_layout_core_macros.svh"

module glwl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    // Vertices delivered so far in the current glyph run.
    logic [2:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            cnt_reg <= m_tlast ? 3'd0 : cnt_reg + 3'd1;
        end
    end

    `GLWL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `GLWL_ASSERT_SAME(a_run_len, aclk, aresetn, m_tvalid && m_tready && m_tlast, cnt_reg == 3'd3 || cnt_reg == 3'd5)
    `GLWL_ASSERT_SAME(a_rst_out, aclk, aresetn, $past(!aresetn), !m_tvalid)
    `GLWL_ASSERT_SAME(a_rst_in, aclk, aresetn, $past(!aresetn), s_tready)

endmodule

bind glyph_line_wrap_layout_core glwl_checker u_glwl_checker (.*);

// ===== sim/tb_glyph_line_wrap_layout_core.sv =====
module tb_glyph_line_wrap_layout_core;
    import glwl_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_GLYPHS = 70;
    localparam int REG_COUNT    = 7;
    localparam int BAD_REG_IDX  = 7;
    localparam int MAX_PRINTS   = 40;

    localparam int REG_LOW  [REG_COUNT] = '{-32768, -32768, 0, 0, 0, 0, 0};
    localparam int REG_HIGH [REG_COUNT] = '{32767, 32767, 65535, 65535, 32767, 32767, 32767};

    typedef struct packed {
        logic [15:0] gw;
        logic [15:0] gh;
        logic [15:0] tl;
        logic [15:0] tt;
        logic [15:0] base;
        logic        first;
    } glyph_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] u;
        logic [15:0] v;
        logic        last;
    } vertex_t;

    typedef struct packed {
        glyph_t  g;
        logic    pinned;
        vertex_t lead;
    } script_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;
    typedef enum {SET_LOW, SET_HIGH, SET_MIXED} setting_style_t;

    // Directed glyphs under the default registers. Where pinned is set, lead is the
    // first word the glyph must produce.
    localparam script_row_t SCRIPT [13] = '{
        // No first glyph since reset: the degenerate word is the cleared corner.
        '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1,
          '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
        '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1,
          '{16'hC000, 16'h4000, 16'h0000, 16'h0000, 1'b0}},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1}, 1'b1,
          '{16'hC000, 16'h4000, 16'hFFFF, 16'hFFFF, 1'b0}},
        // The pen now sits at zero, so this one wraps to the next row.
        '{'{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, '0},
        '{'{16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0}, 1'b0, '0},
        '{'{16'h0100, 16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF, 1'b0}, 1'b0, '0},
        '{'{16'h0100, 16'h0100, 16'h0010, 16'h0010, 16'h0001, 1'b0}, 1'b0, '0},
        '{'{16'h0100, 16'h0100, 16'h0010, 16'h0010, 16'hFFFF, 1'b0}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 1'b0}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0}, 1'b0, '0},
        '{'{16'h0001, 16'h0001, 16'hFFFE, 16'hFFFE, 16'h0000, 1'b1}, 1'b1,
          '{16'hC000, 16'h4000, 16'hFFFE, 16'hFFFE, 1'b0}},
        '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h1000, 1'b0}, 1'b0, '0},
        '{'{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 1'b1}, 1'b0, '0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    // Layout registers and pen state as the block should hold them.
    int cfg_start_x      = START_X_RST;
    int cfg_start_y      = START_Y_RST;
    int cfg_width_scale  = WIDTH_SCALE_RST;
    int cfg_height_scale = HEIGHT_SCALE_RST;
    int cfg_char_gap     = CHAR_GAP_RST;
    int cfg_row_step     = ROW_STEP_RST;
    int cfg_line_height  = LINE_HEIGHT_RST;
    int pen_x            = START_X_RST;
    int pen_y            = START_Y_RST;
    vertex_t corner      = '0;

    vertex_t vertex_q [$];
    int      mismatches = 0;
    int      words_seen = 0;
    int      cycles = 0;
    int      burst_left = 0;
    int      rx_tick = 0;
    int      hold_left = 0;
    bit      hold_due = 1'b0;

    glyph_line_wrap_layout_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch: %s at word %0d: got %h, want %h", what, words_seen, got, want);
        end
    endtask

    function automatic int clamp_s16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int clamp_u16(input longint v);
        return (v > 65535) ? 65535 : int'(v);
    endfunction

    function automatic vertex_t vtx(input int x, input int y, input int u, input int v,
                                   input logic last);
        vertex_t r;
        r.x = 16'(x);
        r.y = 16'(y);
        r.u = 16'(u);
        r.v = 16'(v);
        r.last = last;
        return r;
    endfunction

    function automatic void load_setting(input int idx, input logic [31:0] val);
        case (idx)
            CFG_START_X:      cfg_start_x = int'($signed(val[15:0]));
            CFG_START_Y:      cfg_start_y = int'($signed(val[15:0]));
            CFG_WIDTH_SCALE:  cfg_width_scale = int'(val[15:0]);
            CFG_HEIGHT_SCALE: cfg_height_scale = int'(val[15:0]);
            CFG_CHAR_GAP:     cfg_char_gap = int'(val[14:0]);
            CFG_ROW_STEP:     cfg_row_step = int'(val[14:0]);
            CFG_LINE_HEIGHT:  cfg_line_height = int'(val[14:0]);
            default: ;
        endcase
    endfunction

    // Places one glyph, advances the pen and returns the strip words it yields.
    function automatic void place_glyph(input glyph_t g, output vertex_t run [6],
                                        output int n);
        int w, h, gx, gy, dx, dy, adv, u1, v1, base;
        longint lift;
        w = int'((longint'(g.gw) * cfg_width_scale + 32768) >>> 16);
        if (w > 32767) w = 32767;
        h = int'((longint'(g.gh) * cfg_height_scale + 32768) >>> 16);
        if (h > 32767) h = 32767;
        base = int'($signed(g.base));
        if (g.first) begin
            pen_x = cfg_start_x;
            pen_y = cfg_start_y;
        end
        gx = pen_x;
        gy = pen_y;
        adv = clamp_s16(longint'(pen_x) + cfg_char_gap + w);
        if (adv > 0) begin
            pen_x = cfg_start_x;
            pen_y = clamp_s16(longint'(pen_y) - cfg_row_step);
            gx = pen_x;
            gy = pen_y;
            adv = clamp_s16(longint'(pen_x) + cfg_char_gap + w);
        end
        pen_x = adv;
        // Arithmetic shift floors, so adding half first rounds ties upward.
        lift = (longint'(cfg_line_height) * base + 4096) >>> 13;
        gy = clamp_s16(gy + lift);
        dx = clamp_s16(longint'(gx) + w);
        dy = clamp_s16(longint'(gy) - h);
        u1 = clamp_u16(longint'(g.tl) + g.gw);
        v1 = clamp_u16(longint'(g.tt) + g.gh);
        n = 0;
        if (!g.first) begin
            run[0] = corner;
            run[1] = vtx(gx, gy, g.tl, g.tt, 1'b0);
            n = 2;
        end
        run[n]     = vtx(gx, gy, g.tl, g.tt, 1'b0);
        run[n + 1] = vtx(dx, gy, u1, g.tt, 1'b0);
        run[n + 2] = vtx(gx, dy, g.tl, v1, 1'b0);
        run[n + 3] = vtx(dx, dy, u1, v1, 1'b1);
        n += 4;
        corner = vtx(dx, dy, u1, v1, 1'b0);
    endfunction

    function automatic logic [31:0] choose_setting(input int idx, input setting_style_t style);
        int v;
        case (style)
            SET_LOW:  v = REG_LOW[idx];
            SET_HIGH: v = REG_HIGH[idx];
            default: begin
                case ($urandom_range(0, 7))
                    0: v = REG_LOW[idx];
                    1: v = REG_HIGH[idx];
                    default: v = REG_LOW[idx] + int'($urandom_range(0, REG_HIGH[idx] - REG_LOW[idx]));
                endcase
            end
        endcase
        return 32'(v) & 32'h0000_FFFF;
    endfunction

    // Writes every register in turn; with poke_bad an unmapped index follows.
    task automatic write_registers(input logic [31:0] vals [REG_COUNT], input bit poke_bad);
        int last_idx;
        logic [31:0] val;
        last_idx = poke_bad ? BAD_REG_IDX : CFG_LINE_HEIGHT;
        for (int idx = CFG_START_X; idx <= last_idx; idx++) begin
            val = (idx < REG_COUNT) ? vals[idx] : $urandom;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 5'(idx * 4);
            pwdata  <= val;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            load_setting(idx, val);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one glyph word in the current burst and queues its vertices once taken.
    task automatic send_glyph(input glyph_t g, output vertex_t lead);
        vertex_t run [6];
        int n;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {g.base, g.tt, g.tl, g.gh, g.gw};
        s_tuser  <= g.first;
        do @(posedge aclk); while (!s_tready);
        place_glyph(g, run, n);
        for (int i = 0; i < n; i++) vertex_q.push_back(run[i]);
        lead = run[0];
    endtask

    task automatic wait_drained();
        while (vertex_q.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver runs through its own stall modes; a requested hold-off overrides them.
    always @(posedge aclk) begin
        rx_tick++;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_due) begin
            hold_due = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode_t'(rx_tick[7:6]))
                RX_OPEN:  m_tready <= 1'b1;
                RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
                default:  m_tready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_vertices
        vertex_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (vertex_q.size() == 0) begin
                report("vertex word with nothing expected", m_tdata, '0);
            end else begin
                want = vertex_q.pop_front();
                if (m_tdata[15:0] !== want.x) report("vertex_x", m_tdata[15:0], want.x);
                if (m_tdata[31:16] !== want.y) report("vertex_y", m_tdata[31:16], want.y);
                if (m_tdata[47:32] !== want.u) report("vertex_u", m_tdata[47:32], want.u);
                if (m_tdata[63:48] !== want.v) report("vertex_v", m_tdata[63:48], want.v);
                if (m_tlast !== want.last) report("run_end", m_tlast, want.last);
            end
        end
    end

    initial begin : stimulus
        script_row_t    row;
        vertex_t        lead;
        glyph_t         g;
        logic [31:0]    vals [REG_COUNT];
        setting_style_t style;
        int             left_in_string;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (SCRIPT[i]) begin
            row = SCRIPT[i];
            send_glyph(row.g, lead);
            if (row.pinned && lead !== row.lead) begin
                report("leading vertex of directed glyph", lead[64:1], row.lead[64:1]);
            end
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            style = (p == 1) ? SET_HIGH : (p == 2) ? SET_LOW : SET_MIXED;
            for (int idx = CFG_START_X; idx <= CFG_LINE_HEIGHT; idx++) begin
                vals[idx] = choose_setting(idx, style);
            end
            write_registers(vals, p == 2);
            // Block the output for a long stretch while glyphs keep coming.
            if (p == 0) hold_due = 1'b1;
            left_in_string = 0;
            for (int k = 0; k < PHASE_GLYPHS; k++) begin
                g.gw = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4095))
                                                   : 16'($urandom);
                g.gh = 16'($urandom);
                g.tl = 16'($urandom);
                g.tt = 16'($urandom);
                g.base = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 16383) - 8192)
                                                     : 16'($urandom);
                if (left_in_string == 0) begin
                    left_in_string = $urandom_range(1, 14);
                    // Now and then a string starts without its first-glyph flag.
                    g.first = ($urandom_range(0, 9) != 0);
                end else begin
                    g.first = ($urandom_range(0, 19) == 0);
                end
                left_in_string--;
                send_glyph(g, lead);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
